/* src/pap_pkg.sv */
// Shared types and constants for the prioritized area point query block.
// No dependencies.
`timescale 1ns / 1ps
package pap_pkg;
	localparam int MAX_AREAS    = 64;
	localparam int MAX_VERTICES = 1024;
	localparam int AREA_AW      = $clog2(MAX_AREAS);
	localparam int VERT_AW      = $clog2(MAX_VERTICES);
	localparam int BASE_W       = 17;
	localparam int TRI_W        = 18;
	localparam logic [6:0] NO_HIT = 7'h7f;

	typedef enum logic [1:0] {
		OP_AREA, OP_VERT, OP_QUERY, OP_NONE
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [9:0]         idx;
		logic signed [31:0] px;
		logic signed [31:0] pz;
		logic signed [31:0] bminx;
		logic signed [31:0] bminz;
		logic signed [31:0] bmaxx;
		logic signed [31:0] bmaxz;
		logic signed [15:0] prio;
		logic [10:0]        cnt;
	} item_t;

	typedef struct packed {
		logic signed [31:0] bminx;
		logic signed [31:0] bminz;
		logic signed [31:0] bmaxx;
		logic signed [31:0] bmaxz;
		logic signed [15:0] prio;
		logic [10:0]        cnt;
	} area_t;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] z;
	} vert_t;

	typedef enum logic [3:0] {
		ST_IDLE, ST_AREA_RD, ST_AREA_CHK, ST_TRI_RD0, ST_TRI_RD1, ST_TRI_RD2,
		ST_TRI_RD3, ST_EDGE_MUL, ST_EDGE_CMP, ST_DONE
	} state_t;
endpackage

/* src/pap_front.sv */
// Front part: accepts and classifies input transactions into a two-entry queue.
// Depends on pap_pkg.
`timescale 1ns / 1ps
module pap_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         req_type,
	input  logic [9:0]         entry_index,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_z,
	input  logic signed [31:0] box_min_x,
	input  logic signed [31:0] box_min_z,
	input  logic signed [31:0] box_max_x,
	input  logic signed [31:0] box_max_z,
	input  logic signed [15:0] area_priority,
	input  logic [10:0]        area_vertex_count,
	output logic               deq_valid,
	input  logic               deq,
	output pap_pkg::item_t     deq_item
);
	pap_pkg::item_t slot_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	pap_pkg::item_t in_item;
	logic enq;

	always_comb begin
		in_item.idx   = entry_index;
		in_item.px    = point_x;
		in_item.pz    = point_z;
		in_item.bminx = box_min_x;
		in_item.bminz = box_min_z;
		in_item.bmaxx = box_max_x;
		in_item.bmaxz = box_max_z;
		in_item.prio  = area_priority;
		in_item.cnt   = area_vertex_count;
		case (req_type)
			2'd0:    in_item.op = pap_pkg::OP_AREA;
			2'd1:    in_item.op = pap_pkg::OP_VERT;
			2'd2:    in_item.op = pap_pkg::OP_QUERY;
			default: in_item.op = pap_pkg::OP_NONE;
		endcase
	end

	assign full      = (cnt_q == 2'd2);
	assign deq_valid = (cnt_q != 2'd0);
	assign deq_item  = slot_q[rp_q];
	assign enq       = push && !full;

	always_ff @(posedge clk) begin
		if (enq) slot_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (enq) wp_q <= ~wp_q;
			if (deq) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, enq} - {1'b0, deq};
		end
	end
endmodule

/* src/pap_back.sv */
// Back part: area and vertex stores, query sequencer and result register.
// Depends on pap_pkg.
`timescale 1ns / 1ps
module pap_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [6:0]         num_areas,
	input  logic               deq_valid,
	output logic               deq,
	input  pap_pkg::item_t     deq_item,
	output logic               empty,
	input  logic               pop,
	output logic signed [6:0]  hit_area
);
	pap_pkg::area_t area_mem [pap_pkg::MAX_AREAS];
	pap_pkg::vert_t vert_mem [pap_pkg::MAX_VERTICES];
	pap_pkg::area_t arec_q;
	pap_pkg::vert_t vrd_q, va_q, vb_q, vc_q;
	pap_pkg::state_t st_q, st_d;

	logic [pap_pkg::AREA_AW-1:0] area_addr;
	logic [pap_pkg::VERT_AW-1:0] vert_addr;
	logic [6:0]  ai_q, n_lim;
	logic [pap_pkg::BASE_W-1:0] base_q;
	logic [10:0] k_q;
	logic [1:0]  e_q;
	logic signed [31:0] qx_q, qz_q;
	logic [6:0]  hit_q, res_q;
	logic signed [15:0] hprio_q;
	logic        out_v_q;
	logic [1:0]  s1_q, s2_q;   // {pos, neg}
	logic [pap_pkg::TRI_W-1:0] tri_idx;
	logic        tri_oob, box_ok, more_tri, load_out;
	logic [63:0] mp_q, mq_q;
	logic        np_q, nq_q;
	pap_pkg::vert_t ep, eq;
	logic signed [32:0] da, db, dc, dd;
	logic [31:0] ma, mb, mc, md;
	logic signed [65:0] pv, qv, dv;
	logic [1:0]  sgn;
	logic        tri_hit;

	assign n_lim = (num_areas > 7'(pap_pkg::MAX_AREAS)) ? 7'(pap_pkg::MAX_AREAS) : num_areas;
	assign tri_idx = pap_pkg::TRI_W'(base_q) + pap_pkg::TRI_W'(k_q);
	assign tri_oob = (tri_idx + pap_pkg::TRI_W'(2)) >= pap_pkg::TRI_W'(pap_pkg::MAX_VERTICES);
	assign box_ok = (qx_q >= arec_q.bminx) && (qz_q >= arec_q.bminz) &&
	                (qx_q <= arec_q.bmaxx) && (qz_q <= arec_q.bmaxz);
	assign more_tri = (12'(k_q) + 12'd5) < 12'(arec_q.cnt);
	assign load_out = !out_v_q || pop;
	assign empty    = !out_v_q;
	assign hit_area = res_q;

	// edge operand select: ab, bc, ca
	always_comb begin
		case (e_q)
			2'd0:    begin ep = va_q; eq = vb_q; end
			2'd1:    begin ep = vb_q; eq = vc_q; end
			default: begin ep = vc_q; eq = va_q; end
		endcase
		da = 33'(eq.x) - 33'(ep.x);
		db = 33'(qz_q) - 33'(eq.z);
		dc = 33'(eq.z) - 33'(ep.z);
		dd = 33'(qx_q) - 33'(eq.x);
		ma = da[32] ? 32'(-da) : da[31:0];
		mb = db[32] ? 32'(-db) : db[31:0];
		mc = dc[32] ? 32'(-dc) : dc[31:0];
		md = dd[32] ? 32'(-dd) : dd[31:0];
		pv = np_q ? -$signed({2'b00, mp_q}) : $signed({2'b00, mp_q});
		qv = nq_q ? -$signed({2'b00, mq_q}) : $signed({2'b00, mq_q});
		dv = pv - qv;
		sgn = {(dv > 66'sd0), dv[65]};
		tri_hit = (sgn == 2'b10 && s1_q == 2'b10 && s2_q == 2'b10) ||
		          (sgn == 2'b01 && s1_q == 2'b01 && s2_q == 2'b01);
	end

	always_ff @(posedge clk) begin
		if (st_q == pap_pkg::ST_IDLE && deq_valid && deq_item.op == pap_pkg::OP_AREA &&
		    deq_item.idx < 10'(pap_pkg::MAX_AREAS))
			area_mem[deq_item.idx[pap_pkg::AREA_AW-1:0]] <= '{deq_item.bminx, deq_item.bminz,
				deq_item.bmaxx, deq_item.bmaxz, deq_item.prio, deq_item.cnt};
		if (st_q == pap_pkg::ST_IDLE && deq_valid && deq_item.op == pap_pkg::OP_VERT)
			vert_mem[deq_item.idx[pap_pkg::VERT_AW-1:0]] <= '{deq_item.px, deq_item.pz};
		arec_q <= area_mem[area_addr];
		vrd_q  <= vert_mem[vert_addr];
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			pap_pkg::ST_IDLE: if (deq_valid)
				st_d = (deq_item.op == pap_pkg::OP_QUERY) ? pap_pkg::ST_AREA_RD :
				       pap_pkg::ST_DONE;
			pap_pkg::ST_AREA_RD:
				st_d = (ai_q >= n_lim) ? pap_pkg::ST_DONE : pap_pkg::ST_AREA_CHK;
			pap_pkg::ST_AREA_CHK:
				st_d = (box_ok && arec_q.cnt >= 11'd3) ? pap_pkg::ST_TRI_RD0 :
				       pap_pkg::ST_AREA_RD;
			pap_pkg::ST_TRI_RD0:
				st_d = tri_oob ? pap_pkg::ST_AREA_RD : pap_pkg::ST_TRI_RD1;
			pap_pkg::ST_TRI_RD1:  st_d = pap_pkg::ST_TRI_RD2;
			pap_pkg::ST_TRI_RD2:  st_d = pap_pkg::ST_TRI_RD3;
			pap_pkg::ST_TRI_RD3:  st_d = pap_pkg::ST_EDGE_MUL;
			pap_pkg::ST_EDGE_MUL: st_d = pap_pkg::ST_EDGE_CMP;
			pap_pkg::ST_EDGE_CMP: begin
				if (e_q != 2'd2) st_d = pap_pkg::ST_EDGE_MUL;
				else if (tri_hit || !more_tri) st_d = pap_pkg::ST_AREA_RD;
				else st_d = pap_pkg::ST_TRI_RD0;
			end
			pap_pkg::ST_DONE: if (load_out) st_d = pap_pkg::ST_IDLE;
			default: st_d = pap_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		deq = (st_q == pap_pkg::ST_IDLE) && deq_valid;
		area_addr = ai_q[pap_pkg::AREA_AW-1:0];
		case (st_q)
			pap_pkg::ST_TRI_RD1: vert_addr = pap_pkg::VERT_AW'(tri_idx + pap_pkg::TRI_W'(1));
			pap_pkg::ST_TRI_RD2: vert_addr = pap_pkg::VERT_AW'(tri_idx + pap_pkg::TRI_W'(2));
			default:             vert_addr = tri_idx[pap_pkg::VERT_AW-1:0];
		endcase
	end

	always_ff @(posedge clk) begin
		case (st_q)
			pap_pkg::ST_IDLE: begin
				qx_q <= deq_item.px;
				qz_q <= deq_item.pz;
				ai_q <= 7'd0;
				base_q <= '0;
				hit_q <= pap_pkg::NO_HIT;
				hprio_q <= '0;
			end
			pap_pkg::ST_AREA_CHK: begin
				k_q <= '0;
				if (!(box_ok && arec_q.cnt >= 11'd3)) begin
					base_q <= base_q + pap_pkg::BASE_W'(arec_q.cnt);
					ai_q <= ai_q + 7'd1;
				end
			end
			pap_pkg::ST_TRI_RD0: begin
				e_q <= 2'd0;
				if (tri_oob) begin
					base_q <= base_q + pap_pkg::BASE_W'(arec_q.cnt);
					ai_q <= ai_q + 7'd1;
				end
			end
			pap_pkg::ST_TRI_RD1: va_q <= vrd_q;
			pap_pkg::ST_TRI_RD2: vb_q <= vrd_q;
			pap_pkg::ST_TRI_RD3: vc_q <= vrd_q;
			pap_pkg::ST_EDGE_MUL: begin
				mp_q <= ma * mb;
				mq_q <= mc * md;
				np_q <= da[32] ^ db[32];
				nq_q <= dc[32] ^ dd[32];
			end
			pap_pkg::ST_EDGE_CMP: begin
				e_q <= e_q + 2'd1;
				if (e_q == 2'd0) s1_q <= sgn;
				if (e_q == 2'd1) s2_q <= sgn;
				if (e_q == 2'd2) begin
					if (tri_hit && (hit_q == pap_pkg::NO_HIT || arec_q.prio > hprio_q)) begin
						hit_q <= {1'b0, ai_q[5:0]};
						hprio_q <= arec_q.prio;
					end
					if (tri_hit || !more_tri) begin
						base_q <= base_q + pap_pkg::BASE_W'(arec_q.cnt);
						ai_q <= ai_q + 7'd1;
					end else begin
						k_q <= k_q + 11'd3;
					end
				end
			end
			default: ;
		endcase
		if (st_q == pap_pkg::ST_DONE && load_out) res_q <= hit_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= pap_pkg::ST_IDLE;
			out_v_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == pap_pkg::ST_DONE && load_out) out_v_q <= 1'b1;
			else if (pop) out_v_q <= 1'b0;
		end
	end
endmodule

/* src/prioritized_area_point_query.sv */
// Top level of the prioritized area point query block.
// Depends on pap_pkg, pap_front and pap_back.
//
// Input is a queue: a transaction is taken when push is high and full low.
// Up to two items wait in the front queue while the back part works.
// Results come out as a queue: hit_area is valid while empty is low and
// is taken when pop is high. Every item yields one result; writes and
// unknown requests answer -1.
// A write passes from the queue head through the done state into the result
// register. A query walks the areas one at a time and tests each triangle by
// reading its three vertices over the single vertex memory read port, then
// one edge cross product (two 32x32 multiplies then a compare) at a time; a
// triangle past the vertex table is skipped without reads.
// One item is processed at a time.
// Reset clears num_areas, the queue and the result valid flag; the area and
// vertex stores hold unknown data until written.
// A stalled receiver holds the result; the back part then waits, and once
// the front queue fills, full rises.
// cfg_we writes num_areas from cfg_wdata; write it only while idle.
`timescale 1ns / 1ps
module prioritized_area_point_query (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [6:0]         cfg_wdata,
	input  logic               push,
	output logic               full,
	input  logic [1:0]         req_type,
	input  logic [9:0]         entry_index,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_z,
	input  logic signed [31:0] box_min_x,
	input  logic signed [31:0] box_min_z,
	input  logic signed [31:0] box_max_x,
	input  logic signed [31:0] box_max_z,
	input  logic signed [15:0] area_priority,
	input  logic [10:0]        area_vertex_count,
	output logic               empty,
	input  logic               pop,
	output logic signed [6:0]  hit_area
);
	logic [6:0] num_areas_q;
	logic deq_valid, deq;
	pap_pkg::item_t deq_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) num_areas_q <= 7'd0;
		else if (cfg_we) num_areas_q <= cfg_wdata;
	end

	pap_front u_front (
		.clk, .arst_n, .push, .full, .req_type, .entry_index, .point_x, .point_z,
		.box_min_x, .box_min_z, .box_max_x, .box_max_z, .area_priority,
		.area_vertex_count, .deq_valid, .deq, .deq_item
	);

	pap_back u_back (
		.clk, .arst_n, .num_areas(num_areas_q), .deq_valid, .deq, .deq_item,
		.empty, .pop, .hit_area
	);
endmodule

/* src/pap_checker.sv */
// Port-level checks for prioritized_area_point_query, bound to the top level.
// No package dependency.
`timescale 1ns / 1ps
module pap_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              push,
	input logic              full,
	input logic              empty,
	input logic              pop,
	input logic signed [6:0] hit_area
);
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> (hit_area[6] == 1'b0 || hit_area == -7'sd1))
		else $error("hit_area out of range");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(hit_area)))
		else $error("waiting result changed");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push))
		else $error("full rose without a push");
endmodule

bind prioritized_area_point_query pap_checker u_pap_checker (
	.clk, .arst_n, .push, .full, .empty, .pop, .hit_area
);

/* tb/sv/prioritized_area_point_query_test.sv */
// Self-checking testbench for prioritized_area_point_query: directed table, then random phases.
// Predicts hit_area from its own copy of the area and vertex tables; the directed rows expect no hit.
// Depends on pap_pkg and the RTL of the block.
`timescale 1ns / 1ps
module prioritized_area_point_query_test;
	localparam logic signed [31:0] MINV = 32'sh80000000;
	localparam logic signed [31:0] MAXV = 32'sh7fffffff;
	localparam int K_NORMAL  = 0;
	localparam int K_WIDE    = 1;
	localparam int K_OVER    = 2;
	localparam int K_TAIL    = 3;
	localparam int K_EXTREME = 4;
	localparam int K_ZERO    = 5;

	typedef struct {
		pap_pkg::item_t    it;
		bit                has_want;
		logic signed [6:0] want;
	} dir_row_t;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic [6:0]         cfg_wdata = '0;
	logic               push = 0;
	logic               full;
	logic [1:0]         req_type = '0;
	logic [9:0]         entry_index = '0;
	logic signed [31:0] point_x = '0;
	logic signed [31:0] point_z = '0;
	logic signed [31:0] box_min_x = '0;
	logic signed [31:0] box_min_z = '0;
	logic signed [31:0] box_max_x = '0;
	logic signed [31:0] box_max_z = '0;
	logic signed [15:0] area_priority = '0;
	logic [10:0]        area_vertex_count = '0;
	logic               empty;
	logic               pop = 0;
	logic signed [6:0]  hit_area;

	prioritized_area_point_query DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.push(push), .full(full), .req_type(req_type), .entry_index(entry_index),
		.point_x(point_x), .point_z(point_z), .box_min_x(box_min_x),
		.box_min_z(box_min_z), .box_max_x(box_max_x), .box_max_z(box_max_z),
		.area_priority(area_priority), .area_vertex_count(area_vertex_count),
		.empty(empty), .pop(pop), .hit_area(hit_area)
	);

	always #5 clk = ~clk;

	// shadow copy of the block state
	logic [6:0]     walk_count = '0;
	pap_pkg::area_t zone_tab[pap_pkg::MAX_AREAS];
	bit             zone_set[pap_pkg::MAX_AREAS];
	pap_pkg::vert_t corner_tab[pap_pkg::MAX_VERTICES];
	bit             corner_set[pap_pkg::MAX_VERTICES];

	logic signed [6:0] hit_q[$];
	int  err_cnt = 0;
	int  sent = 0;
	bit  idle_on = 1;
	int  stall_left = 0;
	logic signed [6:0] got_want;

	// phase geometry
	int ph_n, ph_sc, ph_r, vlo, vhi;

	task automatic show_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		err_cnt++;
	endtask

	function automatic int rnd(input int lo, input int hi);
		return lo + int'($urandom_range(0, hi - lo));
	endfunction

	function automatic int side_of(input pap_pkg::vert_t p, input pap_pkg::vert_t q,
			input logic signed [31:0] px, input logic signed [31:0] pz);
		logic signed [67:0] ex, ez, wx, wz, d;
		ex = $signed(q.x) - $signed(p.x);
		ez = $signed(q.z) - $signed(p.z);
		wx = $signed(px) - $signed(q.x);
		wz = $signed(pz) - $signed(q.z);
		d = ex * wz - ez * wx;
		return d > 0 ? 1 : (d < 0 ? -1 : 0);
	endfunction

	function automatic bit tri_hit(input int i0, input logic signed [31:0] px,
			input logic signed [31:0] pz, inout bit bad);
		int s1, s2, s3;
		if (i0 + 2 >= pap_pkg::MAX_VERTICES)
			return 0;
		if (!corner_set[i0] || !corner_set[i0+1] || !corner_set[i0+2])
			bad = 1;
		s1 = side_of(corner_tab[i0], corner_tab[i0+1], px, pz);
		s2 = side_of(corner_tab[i0+1], corner_tab[i0+2], px, pz);
		s3 = side_of(corner_tab[i0+2], corner_tab[i0], px, pz);
		return (s1 > 0 && s2 > 0 && s3 > 0) || (s1 < 0 && s2 < 0 && s3 < 0);
	endfunction

	// walks the areas; bad is set when an unwritten entry would be read
	function automatic logic signed [6:0] find_hit(input logic signed [31:0] px,
			input logic signed [31:0] pz, output bit bad);
		int n, base, hit, k, cnt;
		logic signed [15:0] hp;
		bad = 0;
		hit = -1;
		hp = 0;
		base = 0;
		n = walk_count > pap_pkg::MAX_AREAS ? pap_pkg::MAX_AREAS : walk_count;
		for (int i = 0; i < n; i++) begin
			if (!zone_set[i]) begin
				bad = 1;
				continue;
			end
			cnt = zone_tab[i].cnt;
			if ($signed(px) >= $signed(zone_tab[i].bminx) &&
					$signed(pz) >= $signed(zone_tab[i].bminz) &&
					$signed(px) <= $signed(zone_tab[i].bmaxx) &&
					$signed(pz) <= $signed(zone_tab[i].bmaxz)) begin
				for (k = 0; k + 2 < cnt; k += 3) begin
					if (tri_hit(base + k, px, pz, bad)) begin
						if (hit < 0 || $signed(zone_tab[i].prio) > $signed(hp)) begin
							hit = i;
							hp = zone_tab[i].prio;
						end
						break;
					end
				end
			end
			base += cnt;
		end
		return 7'(hit);
	endfunction

	function automatic logic signed [6:0] apply_item(input pap_pkg::item_t it);
		bit bad;
		case (it.op)
			pap_pkg::OP_AREA: begin
				if (it.idx < pap_pkg::MAX_AREAS) begin
					zone_tab[it.idx] = '{it.bminx, it.bminz, it.bmaxx, it.bmaxz, it.prio, it.cnt};
					zone_set[it.idx] = 1;
				end
			end
			pap_pkg::OP_VERT: begin
				corner_tab[it.idx] = '{it.px, it.pz};
				corner_set[it.idx] = 1;
			end
			pap_pkg::OP_QUERY: return find_hit(it.px, it.pz, bad);
			default: ;
		endcase
		return pap_pkg::NO_HIT;
	endfunction

	function automatic pap_pkg::item_t junk_item();
		pap_pkg::item_t it;
		it.op = pap_pkg::op_t'($urandom_range(0, 3));
		it.idx = 10'($urandom);
		it.px = $urandom;
		it.pz = $urandom;
		it.bminx = $urandom;
		it.bminz = $urandom;
		it.bmaxx = $urandom;
		it.bmaxz = $urandom;
		it.prio = 16'($urandom);
		it.cnt = 11'($urandom);
		return it;
	endfunction

	task automatic send(input pap_pkg::item_t it, input bit has_want = 0,
			input logic signed [6:0] want = pap_pkg::NO_HIT);
		logic signed [6:0] pred;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			push <= 0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push <= 1;
		req_type <= it.op;
		entry_index <= it.idx;
		point_x <= it.px;
		point_z <= it.pz;
		box_min_x <= it.bminx;
		box_min_z <= it.bminz;
		box_max_x <= it.bmaxx;
		box_max_z <= it.bmaxz;
		area_priority <= it.prio;
		area_vertex_count <= it.cnt;
		do @(posedge clk); while (full);
		pred = apply_item(it);
		hit_q.push_back(has_want ? want : pred);
		sent++;
	endtask

	task automatic put_area(input int idx, input logic signed [31:0] x0, z0, x1, z1,
			input logic signed [15:0] prio, input int cnt);
		pap_pkg::item_t it;
		it = junk_item();
		it.op = pap_pkg::OP_AREA;
		it.idx = 10'(idx);
		it.bminx = x0;
		it.bminz = z0;
		it.bmaxx = x1;
		it.bmaxz = z1;
		it.prio = prio;
		it.cnt = 11'(cnt);
		send(it);
	endtask

	task automatic put_vert(input int idx, input logic signed [31:0] x, z);
		pap_pkg::item_t it;
		it = junk_item();
		it.op = pap_pkg::OP_VERT;
		it.idx = 10'(idx);
		it.px = x;
		it.pz = z;
		send(it);
	endtask

	// query, or an unknown request if it would read an unwritten entry
	task automatic put_query(input logic signed [31:0] x, z);
		pap_pkg::item_t it;
		bit bad;
		logic signed [6:0] dummy;
		it = junk_item();
		it.op = pap_pkg::OP_QUERY;
		it.px = x;
		it.pz = z;
		dummy = find_hit(x, z, bad);
		if (bad)
			it.op = pap_pkg::OP_NONE;
		send(it);
	endtask

	function automatic logic signed [31:0] world_pt(input int margin);
		return 32'(rnd(-ph_r - margin, ph_r + margin)) <<< ph_sc;
	endfunction

	function automatic logic signed [31:0] ext_val();
		case ($urandom_range(0, 4))
			0: return MINV;
			1: return MAXV;
			2: return 0;
			3: return -1;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic signed [15:0] pick_prio();
		return $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'(rnd(-2, 2));
	endfunction

	task automatic rand_area(input int idx, input int cnt);
		logic signed [31:0] x0, z0;
		case ($urandom_range(0, 9))
			0: put_area(idx, MAXV, MAXV, MINV, MINV, pick_prio(), cnt);
			1, 2, 3: put_area(idx, world_pt(2), MINV, MAXV, world_pt(2), pick_prio(), cnt);
			4, 5: put_area(idx, -(ph_r + 1) <<< ph_sc, -(ph_r + 1) <<< ph_sc,
				(ph_r + 1) <<< ph_sc, (ph_r + 1) <<< ph_sc, pick_prio(), cnt);
			default: begin
				x0 = world_pt(0);
				z0 = world_pt(0);
				put_area(idx, x0, z0, x0 + (rnd(0, 2 * ph_r) <<< ph_sc),
					z0 + (rnd(0, 2 * ph_r) <<< ph_sc), pick_prio(), cnt);
			end
		endcase
	endtask

	task automatic wait_idle();
		push <= 0;
		while (hit_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic run_phase(input int kind, input int num, input int nrand);
		int total, cnt, v;
		logic signed [31:0] qx, qz;
		wait_idle();
		cfg_we <= 1;
		cfg_wdata <= 7'(num);
		@(posedge clk);
		cfg_we <= 0;
		walk_count = 7'(num);
		ph_sc = kind == K_EXTREME ? 0 : 8 * rnd(0, 2);
		ph_r = 40;
		ph_n = 0;
		vlo = 0;
		vhi = 0;
		case (kind)
			K_EXTREME: begin
				put_area(0, MINV, MINV, MAXV, MAXV, 0, 3);
				put_area(1, MINV, MINV, MAXV, MAXV, 16'(rnd(-1, 1)), 5);
				put_vert(0, MINV, MINV);
				put_vert(1, MAXV, MINV);
				put_vert(2, 0, MAXV);
				for (int i = 3; i < 8; i++)
					put_vert(i, ext_val(), ext_val());
				ph_n = 2;
				vhi = 8;
			end
			K_TAIL: begin
				// area 0 never contains the point, so its vertices stay unread
				put_area(0, MAXV, MAXV, MINV, MINV, 1, 1020);
				put_area(1, MINV, MINV, MAXV, MAXV, pick_prio(), 6);
				put_area(2, MINV, MINV, MAXV, MAXV, pick_prio(), 2047);
				for (int i = 1020; i < 1024; i++)
					put_vert(i, world_pt(0), world_pt(0));
				ph_n = 3;
				vlo = 1020;
				vhi = 1024;
			end
			K_ZERO: vhi = 0;
			default: begin
				ph_n = kind == K_NORMAL ? rnd(1, 10) : pap_pkg::MAX_AREAS;
				total = 0;
				for (int i = 0; i < ph_n; i++) begin
					cnt = kind == K_WIDE ? 3 : (kind == K_OVER ? rnd(0, 4) : rnd(0, 12));
					rand_area(i, cnt);
					total += cnt;
				end
				vhi = total > pap_pkg::MAX_VERTICES ? pap_pkg::MAX_VERTICES : total;
				for (int i = 0; i < vhi; i++)
					put_vert(i, world_pt(0), world_pt(0));
			end
		endcase
		for (int j = 0; j < nrand; j++) begin
			v = $urandom_range(0, 99);
			if (v < 60) begin
				if (kind == K_EXTREME) begin
					qx = ext_val();
					qz = ext_val();
				end else if (vhi > vlo && $urandom_range(0, 4) == 0) begin
					// on a vertex, or on the edge to the next one
					cnt = rnd(vlo, vhi - 1);
					qx = corner_tab[cnt].x;
					qz = corner_tab[cnt].z;
					if (cnt + 1 < vhi && $urandom_range(0, 1) == 0 &&
							qx[0] == corner_tab[cnt+1].x[0] && qz[0] == corner_tab[cnt+1].z[0]) begin
						qx = ($signed(qx) + $signed(corner_tab[cnt+1].x)) >>> 1;
						qz = ($signed(qz) + $signed(corner_tab[cnt+1].z)) >>> 1;
					end
				end else begin
					qx = world_pt(4);
					qz = world_pt(4);
				end
				put_query(qx, qz);
			end else if (v < 70) begin
				if (vhi > vlo)
					put_vert(rnd(vlo, vhi - 1), world_pt(0), world_pt(0));
				else
					put_vert(rnd(0, 1023), $urandom, $urandom);
			end else if (v < 78 && ph_n > 0 && kind != K_TAIL) begin
				cnt = rnd(0, ph_n - 1);
				rand_area(cnt, zone_tab[cnt].cnt);
			end else if (v < 85) begin
				put_area(rnd(pap_pkg::MAX_AREAS, 1023), $urandom, $urandom, $urandom, $urandom,
					16'($urandom), int'($urandom_range(0, 2047)));
			end else if (v < 90) begin
				send(junk_item() | {pap_pkg::OP_NONE, 229'(0)});
			end else if (v < 95) begin
				put_query($urandom, $urandom);
			end else if (ph_n < pap_pkg::MAX_AREAS) begin
				// area past the ones this phase sets up
				put_area(rnd(ph_n, pap_pkg::MAX_AREAS - 1), $urandom, $urandom, $urandom,
					$urandom, 16'($urandom), int'($urandom_range(0, 2047)));
			end else begin
				put_query(world_pt(4), world_pt(4));
			end
		end
	endtask

	function automatic dir_row_t row(input pap_pkg::op_t op, input int idx,
			input logic signed [31:0] px, pz, x0, z0, x1, z1,
			input logic signed [15:0] prio, input int cnt);
		dir_row_t r;
		r.it = '{op, 10'(idx), px, pz, x0, z0, x1, z1, prio, 11'(cnt)};
		r.has_want = 1;
		r.want = pap_pkg::NO_HIT;
		return r;
	endfunction

	// result side: random pop stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pop <= 0;
			stall_left = 0;
		end else begin
			if (pop && !empty) begin
				if (hit_q.size() == 0) begin
					show_mismatch($sformatf("unexpected result hit_area=%0d", hit_area));
				end else begin
					got_want = hit_q.pop_front();
					if (hit_area !== got_want)
						show_mismatch($sformatf("hit_area=%0d expected %0d", hit_area, got_want));
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				pop <= 0;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				stall_left = $urandom_range(0, 3);
				pop <= 0;
			end else begin
				pop <= 1;
			end
		end
	end

	initial begin
		#(100_000_000);
		$display("FAIL");
		$finish;
	end

	initial begin
		dir_row_t dir_tab[$];
		repeat (5) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// walk count is zero after reset: every item answers no hit
		dir_tab.push_back(row(pap_pkg::OP_QUERY, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(pap_pkg::OP_QUERY, 1023, MINV, MINV, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(pap_pkg::OP_QUERY, 0, MAXV, MAXV, -1, -1, -1, -1, -1, 2047));
		dir_tab.push_back(row(pap_pkg::OP_NONE, 1023, -1, -1, -1, -1, -1, -1, -1, 2047));
		dir_tab.push_back(row(pap_pkg::OP_NONE, 0, 0, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(pap_pkg::OP_AREA, 0, 0, 0, MINV, MINV, MAXV, MAXV,
			16'sh7fff, 1024));
		dir_tab.push_back(row(pap_pkg::OP_AREA, 63, -1, -1, MAXV, MAXV, MINV, MINV,
			16'sh8000, 2047));
		dir_tab.push_back(row(pap_pkg::OP_AREA, 64, 0, 0, 0, 0, 0, 0, 0, 3));
		dir_tab.push_back(row(pap_pkg::OP_AREA, 1023, -1, -1, -1, -1, -1, -1, -1, 2047));
		dir_tab.push_back(row(pap_pkg::OP_VERT, 0, MAXV, MINV, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(pap_pkg::OP_VERT, 1023, MINV, MAXV, -1, -1, -1, -1, -1, 2047));
		dir_tab.push_back(row(pap_pkg::OP_VERT, 512, -1, 0, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(pap_pkg::OP_QUERY, 0, MAXV, MINV, 0, 0, 0, 0, 0, 0));
		dir_tab.push_back(row(pap_pkg::OP_QUERY, 0, -1, 1, 0, 0, 0, 0, 0, 0));
		foreach (dir_tab[i])
			send(dir_tab[i].it, dir_tab[i].has_want, dir_tab[i].want);

		run_phase(K_EXTREME, 2, 100);
		run_phase(K_TAIL, 3, 100);
		run_phase(K_WIDE, 64, 40);
		run_phase(K_OVER, 127, 40);
		run_phase(K_ZERO, 0, 60);
		while (sent < 1350) begin
			idle_on = $urandom_range(0, 3) != 0;
			run_phase(K_NORMAL, rnd(1, 10), 100);
		end
		idle_on = 0;
		run_phase(K_NORMAL, rnd(1, 10), 100);

		push <= 0;
		while (hit_q.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (err_cnt == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end
endmodule

/* prioritized_area_point_query.f */
src/pap_pkg.sv
src/pap_front.sv
src/pap_back.sv
src/prioritized_area_point_query.sv
src/pap_checker.sv
tb/sv/prioritized_area_point_query_test.sv
